FILE: rtl/rcsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared constants and types for the serial RC frame deframer.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

   // Frame geometry.
   localparam int NUM_CHANNELS = 14;
   localparam int BODY_END     = 2 + 2 * NUM_CHANNELS;
   localparam int FRAME_LEN    = BODY_END + 2;
   localparam int POS_W        = $clog2(FRAME_LEN);
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_W       = 4;

   // Header bytes and checksum seed.
   localparam logic [7:0]  HDR_FIRST  = 8'h20;
   localparam logic [7:0]  HDR_SECOND = 8'h40;
   localparam logic [15:0] SUM_INIT   = 16'hFFFF;

   // Named byte positions.
   localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR2    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_BODY    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_BODYEND = POS_W'(BODY_END);
   localparam logic [POS_W-1:0] POS_TRAILER = POS_W'(FRAME_LEN - 1);

   // Status from the parser to the burst logic.
   typedef struct packed {
      logic frame_good;    // trailer accepted and checksum matched
      logic trailer_next;  // next accepted beat completes a frame
   } parse_status_type;

   typedef logic [15:0] word_type;

endpackage
`default_nettype wire

FILE: rtl/rcsfd_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_frame_parser
// Byte-position tracking, checksum and channel word assembly for one frame.
// ----------------------------------------------------------------------------
module rcsfd_frame_parser
   import rcsfd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   output parse_status_type      status,
   output word_type              words [NUM_CHANNELS]
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       hold_ff, hold_in;
   word_type         store_ff [NUM_CHANNELS];
   logic             wr_en;
   logic [POS_W-1:0] pos_m3;
   logic [IDX_W-1:0] wr_idx;
   logic             good;

   // Channel word k has its high byte at position 2k+3.
   assign pos_m3 = pos_ff - POS_W'(3);
   assign wr_idx = IDX_W'(pos_m3 >> 1);

   // Next state for each accepted beat.
   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      hold_in = hold_ff;
      wr_en   = 1'b0;
      good    = 1'b0;
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == HDR_FIRST) begin
               sum_in = SUM_INIT - {8'h00, HDR_FIRST};
               pos_in = POS_HDR2;
            end
         end else if (pos_ff == POS_HDR2) begin
            if (rx_byte != HDR_SECOND) begin
               pos_in = POS_HUNT;
            end else begin
               sum_in = sum_ff - {8'h00, rx_byte};
               pos_in = POS_BODY;
            end
         end else if (pos_ff < POS_BODYEND) begin
            sum_in = sum_ff - {8'h00, rx_byte};
            if (!pos_ff[0]) begin
               hold_in = rx_byte;
            end else begin
               wr_en = 1'b1;
            end
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == POS_BODYEND) begin
            hold_in = rx_byte;
            pos_in  = pos_ff + POS_W'(1);
         end else begin
            // Trailer high byte: the frame ends either way.
            pos_in = POS_HUNT;
            good   = ({rx_byte, hold_ff} == sum_ff);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         sum_ff  <= SUM_INIT;
         hold_ff <= 8'h00;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         hold_ff <= hold_in;
      end
   end

   // Channel store, written one word per high byte.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= {rx_byte, hold_ff};
      end
   end

   assign words               = store_ff;
   assign status.frame_good   = good;
   assign status.trailer_next = (pos_ff == POS_TRAILER);

endmodule
`default_nettype wire

FILE: rtl/rc_serial_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_serial_frame_deframer
// Hunts for servo frames in a serial byte stream, checks the trailer
// checksum and emits every channel word of each good frame.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_     in         rx_byte (8)
//  rsp_     out        channel_index (4), channel_value (16), last_channel (1)
//
// One byte is taken per cycle while req_stall is low. A good frame yields a
// burst of NUM_CHANNELS beats, one per cycle while rsp_stall is low, from a
// snapshot buffer and the output register. req_stall rises only when the
// next byte would end a frame while the previous burst is still draining.
// Reset clears the control state; the channel store needs no clearing pass.
// ----------------------------------------------------------------------------
module rc_serial_frame_deframer
   import rcsfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CHAN_W-1:0]      rsp_channel_index,
   output logic [15:0]            rsp_channel_value,
   output logic                   rsp_last_channel
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   parse_status_type  status;
   word_type          words [NUM_CHANNELS];
   logic              accept;
   logic              load_out;

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   word_type          buf_ff [NUM_CHANNELS];

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_index_ff;
   logic [15:0]       rsp_value_ff;
   logic              rsp_last_ff;

   assign req_stall = busy_ff && status.trailer_next;
   assign accept    = req_valid && !req_stall;
   assign load_out  = !rsp_valid_ff || !rsp_stall;

   rcsfd_frame_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .status  (status),
      .words   (words)
   );

   // Burst sequencer: start on a good frame, step on each output load.
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (status.frame_good) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && load_out) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Snapshot of the frame so the next frame may overwrite the store.
   always_ff @(posedge clock) begin
      if (status.frame_good) begin
         buf_ff <= words;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_index_ff <= CHAN_W'(idx_ff);
         rsp_value_ff <= buf_ff[idx_ff];
         rsp_last_ff  <= (idx_ff == LAST_IDX);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last_channel  = rsp_last_ff;

`ifndef SYNTH
   // A frame never completes while a burst is still being read out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      status.frame_good |-> !busy_ff)
      else $error("frame completed during an active burst");

   // Within a burst the channel index steps by one each beat.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_channel |=>
         rsp_valid && (rsp_channel_index == CHAN_W'($past(rsp_channel_index) + 1'b1)))
      else $error("channel index did not advance within a burst");

   // The last flag marks the final channel only.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_channel |->
         rsp_channel_index == CHAN_W'(NUM_CHANNELS - 1))
      else $error("last flag on a channel other than the final one");

   // A burst begins at channel zero.
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      status.frame_good |=> idx_ff == '0 && busy_ff)
      else $error("burst did not start at channel zero");
`endif

endmodule
`default_nettype wire
